// ===== sv/lps_pkg.sv =====
`timescale 1ns / 1ps

package lps_pkg;

    // Fixed field widths of the request and result items
    localparam int PAGE_W     = 10;
    localparam int PAGE_SPAN  = 1 << PAGE_W;
    localparam int SLOT_OUT_W = 4;
    localparam int MAXS_W     = 5;

    // Defaults for the top level parameters
    localparam int SLOTS_DEF = 16;
    localparam int PAGES_DEF = 1024;

    // Reset value of the slot limit register
    localparam logic [MAXS_W-1:0] MAXS_RESET = MAXS_W'(16);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_UPD
    } t_state;

endpackage

// ===== sv/lps_mod.sv =====
`timescale 1ns / 1ps

// Request page latch with a reciprocal-multiply remainder: the quotient is
// formed as the page is latched, then subtracted out in a single step.
module lps_mod import lps_pkg::*; #(
    parameter int PAGES = PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [PAGE_W-1:0] i_page,
    input  logic              i_step,
    output logic [PAGE_W-1:0] o_rem,
    output logic              o_last
);

    localparam int     DW    = 2 * PAGE_W;
    localparam int     SH    = 2 * PAGE_W + 1;
    localparam int     MW    = SH + 1;
    localparam int     PRW   = PAGE_W + MW;
    localparam longint RECIP = ((longint'(1) << SH) + longint'(PAGES) - 1) / longint'(PAGES);

    logic [PAGE_W-1:0] r_rem;
    logic [PAGE_W-1:0] r_q;
    logic [PRW-1:0]    q_prod;
    logic [DW-1:0]     q_back;
    logic [PAGE_W-1:0] diff;

    // Estimate the quotient by the scaled reciprocal, then take it back out
    always_comb begin
        q_prod = PRW'(i_page) * PRW'(RECIP);
        q_back = DW'(r_q) * DW'(PAGES);
        diff   = r_rem - q_back[PAGE_W-1:0];
    end

    // Latch the page and its quotient, then subtract in one step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_load) begin
            r_rem <= i_page;
            r_q   <= q_prod[SH +: PAGE_W];
        end else if (i_step) begin
            r_rem <= diff;
            r_q   <= '0;
        end
    end

    assign o_rem  = r_rem;
    assign o_last = 1'b1;

endmodule

// ===== sv/lps_cell.sv =====
`timescale 1ns / 1ps

// One recency position: holds a slot and its owner page, compares the
// owner against the request and takes its neighbor's entry on shift.
module lps_cell import lps_pkg::*; #(
    parameter int SW = 4,
    parameter int PW = PAGE_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_in_valid,
    input  logic [SW-1:0] i_in_slot,
    input  logic [PW-1:0] i_in_page,
    input  logic [PW-1:0] i_page,
    output logic          o_valid,
    output logic [SW-1:0] o_slot,
    output logic [PW-1:0] o_page,
    output logic          o_match
);

    logic          r_valid;
    logic [SW-1:0] r_slot;
    logic [PW-1:0] r_page;

    // Clear the occupancy at reset, advance on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_in_valid;
        end
    end

    // Take the neighbor's entry on shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_slot <= i_in_slot;
            r_page <= i_in_page;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;
    assign o_page  = r_page;
    assign o_match = r_valid && (r_page == i_page);

endmodule

// ===== sv/lru_page_slot_cache.sv =====
// Sequence: a request accepted in idle passes through the update state, where the
// cell row is looked up and shifted, after a reduction state when PAGES is below 1024;
// the result is registered behind the update state. busy stays high until the update
// state is left, so the block takes no new request before it is through with the last.
// Results cannot be held off: o_done marks each for exactly one cycle.
// Reset empties all slots and sets the slot limit to 16; no clearing pass.
`timescale 1ns / 1ps

module lru_page_slot_cache import lps_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int PAGES = PAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [MAXS_W-1:0]     i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [PAGE_W-1:0]     i_page,
    output logic                  o_done,
    output logic                  o_hit,
    output logic [SLOT_OUT_W-1:0] o_slot,
    output logic                  o_evicted_valid,
    output logic [PAGE_W-1:0]     o_evicted_page
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = (PAGES >= PAGE_SPAN) ? PAGE_W : ((PAGES > 1) ? $clog2(PAGES) : 1);
    localparam int UW = $clog2(SLOTS + 1);
    localparam int LW = (UW > MAXS_W) ? UW : MAXS_W;
    localparam int XW = (SW > SLOT_OUT_W) ? SW : SLOT_OUT_W;
    localparam bit NEED_MOD = (PAGES < PAGE_SPAN);

    t_state r_state;
    t_state n_state;

    logic              busy_int;
    logic              upd;
    logic              mod_step;
    logic              load;
    logic [PAGE_W-1:0] rem;
    logic              mod_last;
    logic [PW-1:0]     page_red;

    logic [MAXS_W-1:0] r_max_slots;
    logic [UW-1:0]     r_used;
    logic [UW-1:0]     n_used;

    logic [SLOTS-1:0]  c_valid;
    logic [SLOTS-1:0]  c_match;
    logic [SLOTS-1:0]  c_shift;
    logic [SLOTS-1:0]  c_last;
    logic [SW-1:0]     c_slot [SLOTS];
    logic [PW-1:0]     c_page [SLOTS];
    logic              c_in_valid [SLOTS];
    logic [SW-1:0]     c_in_slot [SLOTS];
    logic [PW-1:0]     c_in_page [SLOTS];

    logic              hit;
    logic              fresh;
    logic              evict;
    logic [SW-1:0]     hit_slot;
    logic [SW-1:0]     ev_slot;
    logic [PW-1:0]     ev_page;
    logic [SW-1:0]     front_slot;
    logic [XW-1:0]     slot_x;
    logic [LW-1:0]     lim_raw;
    logic [LW-1:0]     lim;

    logic                  r_done;
    logic                  r_hit;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic                  r_ev_valid;
    logic [PAGE_W-1:0]     r_ev_page;

    // Hold the slot limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_slots <= MAXS_RESET;
        end else if (i_cfg_we) begin
            r_max_slots <= i_cfg_wdata;
        end
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = NEED_MOD ? ST_MOD : ST_UPD;
                end
            end
            ST_MOD: begin
                if (mod_last) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        busy_int = 1'b1;
        upd      = 1'b0;
        mod_step = 1'b0;
        unique case (r_state)
            ST_IDLE: busy_int = 1'b0;
            ST_MOD:  mod_step = 1'b1;
            ST_UPD:  upd      = 1'b1;
            default: busy_int = 1'b1;
        endcase
    end

    assign busy = busy_int;
    assign load = start && !busy_int;

    // Latch and reduce the requested page
    lps_mod #(
        .PAGES (PAGES)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_page  (i_page),
        .i_step  (mod_step),
        .o_rem   (rem),
        .o_last  (mod_last)
    );

    assign page_red = rem[PW-1:0];

    // Row of recency cells, most recent at position zero
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        localparam logic [UW-1:0] POS = UW'(g);

        if (g == 0) begin : g_front
            assign c_in_valid[g] = 1'b1;
            assign c_in_slot[g]  = front_slot;
            assign c_in_page[g]  = page_red;
        end else begin : g_link
            assign c_in_valid[g] = c_valid[g-1];
            assign c_in_slot[g]  = c_slot[g-1];
            assign c_in_page[g]  = c_page[g-1];
        end

        if (g == SLOTS - 1) begin : g_tail
            assign c_last[g] = c_valid[g];
        end else begin : g_body
            assign c_last[g] = c_valid[g] && !c_valid[g+1];
        end

        // Shift up to the hit position, or over the used slots on a miss (one more when fresh)
        assign c_shift[g] = upd && (hit ? (|c_match[SLOTS-1:g])
                                        : ((POS < r_used) || (fresh && POS == r_used)));

        lps_cell #(
            .SW (SW),
            .PW (PW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (c_shift[g]),
            .i_in_valid (c_in_valid[g]),
            .i_in_slot  (c_in_slot[g]),
            .i_in_page  (c_in_page[g]),
            .i_page     (page_red),
            .o_valid    (c_valid[g]),
            .o_slot     (c_slot[g]),
            .o_page     (c_page[g]),
            .o_match    (c_match[g])
        );
    end

    // Select the hit slot and the least recent entry
    always_comb begin
        hit_slot = '0;
        ev_slot  = '0;
        ev_page  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_slot = hit_slot | (c_match[i] ? c_slot[i] : '0);
            ev_slot  = ev_slot  | (c_last[i]  ? c_slot[i] : '0);
            ev_page  = ev_page  | (c_last[i]  ? c_page[i] : '0);
        end
    end

    // Clip the limit to one through SLOTS
    always_comb begin
        lim_raw = LW'(r_max_slots);
        if (lim_raw == '0) begin
            lim = LW'(1);
        end else if (lim_raw > LW'(SLOTS)) begin
            lim = LW'(SLOTS);
        end else begin
            lim = lim_raw;
        end
    end

    assign hit        = |c_match;
    assign fresh      = !hit && (LW'(r_used) < lim);
    assign evict      = !hit && !fresh;
    assign front_slot = hit ? hit_slot : (fresh ? SW'(r_used) : ev_slot);
    assign slot_x     = XW'(front_slot);
    assign n_used     = (upd && fresh) ? r_used + UW'(1) : r_used;

    // Count slots in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    // Strobe the result for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= upd;
        end
    end

    // Hold the result fields
    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_hit      <= hit;
            r_slot     <= slot_x[SLOT_OUT_W-1:0];
            r_ev_valid <= evict;
            r_ev_page  <= evict ? PAGE_W'(ev_page) : '0;
        end
    end

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;

    // A page is held by at most one slot
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(c_match))
        else $error("request page matches more than one slot");

    // Occupied cells agree with the slot count
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(c_valid) == r_used)
        else $error("occupied cells disagree with slot count");

    // A result follows only the update cycle
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_UPD))
        else $error("result strobe without an update cycle");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_hit && r_ev_valid))
        else $error("hit reported together with an eviction");

    // Occupancy never grows past the slot count
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd && fresh |-> r_used < UW'(SLOTS))
        else $error("fresh slot taken with all slots in use");

endmodule

// ===== verif/lru_page_slot_cache_test.sv =====
`timescale 1ns / 1ps

module lru_page_slot_cache_test;
    import lps_pkg::*;

    localparam int SLOT_COUNT  = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted_valid;
        logic [PAGE_W-1:0]     evicted_page;
    } t_slot_map;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [MAXS_W-1:0]     i_cfg_wdata = MAXS_RESET;
    logic                  start = 1'b0;
    logic                  busy;
    logic [PAGE_W-1:0]     i_page = '0;
    logic                  o_done;
    logic                  o_hit;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic                  o_evicted_valid;
    logic [PAGE_W-1:0]     o_evicted_page;

    // Predicted cache contents
    logic                  page_held [PAGE_SPAN];
    logic [SLOT_OUT_W-1:0] page_slot [PAGE_SPAN];
    logic [PAGE_W-1:0]     slot_page [SLOT_COUNT];
    int unsigned           slot_last_use [SLOT_COUNT];
    int                    slots_taken = 0;
    int unsigned           use_tick = 0;
    logic [MAXS_W-1:0]     limit_reg = MAXS_RESET;

    t_slot_map pending_maps[$];
    int        errors = 0;
    int        cycles = 0;

    lru_page_slot_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_page          (i_page),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Map one page and update the predicted state; LRU is the smallest use stamp
    function automatic t_slot_map map_page(input logic [PAGE_W-1:0] pg);
        t_slot_map r;
        int        cap;
        int        s;
        r = '0;
        if (limit_reg == 0)
            cap = 1;
        else if (int'(limit_reg) > SLOT_COUNT)
            cap = SLOT_COUNT;
        else
            cap = int'(limit_reg);
        use_tick++;
        if (page_held[pg]) begin
            r.hit = 1'b1;
            r.slot = page_slot[pg];
            slot_last_use[page_slot[pg]] = use_tick;
        end else begin
            if (slots_taken < cap) begin
                s = slots_taken;
                slots_taken++;
            end else begin
                s = 0;
                for (int k = 1; k < slots_taken; k++)
                    if (slot_last_use[k] < slot_last_use[s])
                        s = k;
                r.evicted_valid = 1'b1;
                r.evicted_page = slot_page[s];
                page_held[slot_page[s]] = 1'b0;
            end
            slot_page[s] = pg;
            slot_last_use[s] = use_tick;
            page_held[pg] = 1'b1;
            page_slot[pg] = SLOT_OUT_W'(s);
            r.slot = SLOT_OUT_W'(s);
        end
        return r;
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_page(input logic [PAGE_W-1:0] pg);
        start <= 1'b1;
        i_page <= pg;
        do @(posedge i_clk); while (busy);
        pending_maps.push_back(map_page(pg));
    endtask

    task automatic idle(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [MAXS_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    // Limit of zero behaves as one slot: once it is filled, every new page evicts the last
    task automatic test_single_slot();
        write_limit('0);
        send_page(10'd0);
        send_page(10'd0);
        send_page(10'd1023);
        send_page(10'd1023);
        send_page(10'd0);
        write_limit(5'd1);
        send_page(10'd0);
        send_page(10'd5);
    endtask

    // Fill a few fresh slots, then lower the limit below the slots in use
    task automatic test_limit_lowered();
        write_limit(5'd5);
        send_page(10'd1023);
        send_page(10'h155);
        send_page(10'h2AA);
        send_page(10'd1);
        send_page(10'd2);
        send_page(10'd1023);
        write_limit(5'd2);
        send_page(10'd3);
        send_page(10'h2AA);
    endtask

    // Limit above the slot count acts as the slot count
    task automatic test_limit_above_range();
        write_limit(5'd31);
        for (int k = 0; k < 12; k++)
            send_page(PAGE_W'(100 + k));
        send_page(10'd0);
    endtask

    // Bursts drawn mostly from a small set of hot pages, the rest anywhere
    task automatic test_random_traffic(input int n, input int pool_n, input bit no_gaps);
        logic [PAGE_W-1:0] hot [24];
        int                sent;
        int                burst;
        foreach (hot[k])
            hot[k] = PAGE_W'($urandom);
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n; k++) begin
                if ($urandom_range(0, 9) < 7)
                    send_page(hot[$urandom_range(0, pool_n - 1)]);
                else
                    send_page(PAGE_W'($urandom));
                sent++;
            end
            if (!no_gaps)
                idle($urandom_range(1, 6));
        end
    endtask

    initial begin
        foreach (page_held[k]) begin
            page_held[k] = 1'b0;
            page_slot[k] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_slot();
        test_limit_lowered();
        test_limit_above_range();

        write_limit(5'd16);
        test_random_traffic(150, 20, 1'b0);
        write_limit(5'd17);
        test_random_traffic(150, 8, 1'b1);
        write_limit('0);
        test_random_traffic(150, 24, 1'b0);
        write_limit(MAXS_W'($urandom));
        test_random_traffic(150, 17, 1'b0);
        drain();
        write_limit(MAXS_W'($urandom));
        test_random_traffic(150, 12, 1'b1);
        write_limit(5'd31);
        test_random_traffic(150, 3, 1'b0);

        // Let the last results land, then report
        drain();
        repeat (12) @(posedge i_clk);
        if (errors == 0)
            $display("lru_page_slot_cache_test: clean");
        else
            $display("lru_page_slot_cache_test: errors");
        $finish;
    end

    // Compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_slot_map want;
        if (i_rst_n && o_done) begin
            if (pending_maps.size() == 0) begin
                $display("%0t: unexpected result hit=%0b slot=%0d ev=%0b ev_page=%0d",
                         $time, o_hit, o_slot, o_evicted_valid, o_evicted_page);
                errors++;
            end else begin
                want = pending_maps.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                    errors++;
                end
                if (o_slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, o_slot);
                    errors++;
                end
                if (o_evicted_valid !== want.evicted_valid) begin
                    $display("%0t: evicted_valid expected %0b actual %0b",
                             $time, want.evicted_valid, o_evicted_valid);
                    errors++;
                end
                if (o_evicted_page !== want.evicted_page) begin
                    $display("%0t: evicted_page expected %0d actual %0d",
                             $time, want.evicted_page, o_evicted_page);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("lru_page_slot_cache_test: errors");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
sv/lps_pkg.sv
sv/lps_mod.sv
sv/lps_cell.sv
sv/lru_page_slot_cache.sv
verif/lru_page_slot_cache_test.sv
